>>> design/tlca_pkg.sv
// ----------------------------------------------------------------------------
// tlca_pkg: shared types and constants for the LCA parent-climb block
// Node width, table entry layout, request kinds, table access bundle and
// the climb sequencer states.
// ----------------------------------------------------------------------------
package tlca_pkg;

   localparam int NODE_W      = 10;
   localparam int TABLE_DEPTH = 1 << NODE_W;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;

   typedef logic [NODE_W-1:0] node_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef struct packed {
      node_type level;
      node_type parent;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      node_type  wr_addr;
      entry_type wr_entry;
      node_type  rd_addr0;
      node_type  rd_addr1;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHOOSE,
      ST_LIFT_DEPTH,
      ST_WAIT_ONE,
      ST_LIFT_PAIR,
      ST_WAIT_TWO
   } state_type;

endpackage

>>> design/tlca_table.sv
// ----------------------------------------------------------------------------
// tlca_table: parent and depth table
// One write port and two registered read ports over one entry per node.
// ----------------------------------------------------------------------------
module tlca_table (
   input  logic                  clock,
   input  tlca_pkg::mem_req_type mem_req,
   output tlca_pkg::entry_type   rd_data0,
   output tlca_pkg::entry_type   rd_data1
);

   tlca_pkg::entry_type mem [tlca_pkg::TABLE_DEPTH];
   tlca_pkg::entry_type rd0_ff;
   tlca_pkg::entry_type rd1_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_entry;
      end
      rd0_ff <= mem[mem_req.rd_addr0];
      rd1_ff <= mem[mem_req.rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

>>> design/tlca_climb.sv
// ----------------------------------------------------------------------------
// tlca_climb: climb sequencer
// Decodes transactions, lifts the deeper node until depths match, then
// lifts both nodes until they meet, bounded by a step counter.
// ----------------------------------------------------------------------------
module tlca_climb #(
   parameter int NODE_COUNT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tlca_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tlca_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output tlca_pkg::mem_req_type               mem_req,
   input  tlca_pkg::entry_type                 rd_data0,
   input  tlca_pkg::entry_type                 rd_data1
);

   localparam int STEP_W = $clog2(NODE_COUNT + 1);
   localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(NODE_COUNT);

   tlca_pkg::state_type state_ff, state_in;
   tlca_pkg::node_type  x_ff, x_in;
   tlca_pkg::node_type  y_ff, y_in;
   tlca_pkg::entry_type xe_ff, xe_in;
   tlca_pkg::entry_type ye_ff, ye_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tlca_pkg::node_type  rsp_anc_ff, rsp_anc_in;
   logic                rsp_found_ff, rsp_found_in;

   tlca_pkg::node_type  in_a, in_b, in_level;
   logic                accept, is_query, out_free, at_bound;
   logic                done, done_found;

   assign in_a     = req_tdata[tlca_pkg::NODE_W-1:0];
   assign in_b     = req_tdata[2*tlca_pkg::NODE_W-1:tlca_pkg::NODE_W];
   assign in_level = req_tdata[3*tlca_pkg::NODE_W-1:2*tlca_pkg::NODE_W];
   assign accept   = req_tvalid && req_tready;
   assign is_query = (tlca_pkg::req_kind_type'(req_tuser) == tlca_pkg::REQ_QUERY);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign at_bound = (steps_ff >= STEP_MAX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlca_pkg::ST_IDLE: begin
            if (accept && is_query) state_in = tlca_pkg::ST_CHOOSE;
         end
         tlca_pkg::ST_CHOOSE: state_in = tlca_pkg::ST_LIFT_DEPTH;
         tlca_pkg::ST_LIFT_DEPTH: begin
            if (xe_ff.level != ye_ff.level) begin
               if (at_bound) begin
                  if (out_free) state_in = tlca_pkg::ST_IDLE;
               end else begin
                  state_in = tlca_pkg::ST_WAIT_ONE;
               end
            end else begin
               state_in = tlca_pkg::ST_LIFT_PAIR;
            end
         end
         tlca_pkg::ST_WAIT_ONE: state_in = tlca_pkg::ST_LIFT_DEPTH;
         tlca_pkg::ST_LIFT_PAIR: begin
            if (x_ff != y_ff && !at_bound) begin
               state_in = tlca_pkg::ST_WAIT_TWO;
            end else if (out_free) begin
               state_in = tlca_pkg::ST_IDLE;
            end
         end
         tlca_pkg::ST_WAIT_TWO: state_in = tlca_pkg::ST_LIFT_PAIR;
         default: state_in = tlca_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready       = (state_ff == tlca_pkg::ST_IDLE);
      mem_req.wr_en    = accept && !is_query;
      mem_req.wr_addr  = in_a;
      mem_req.wr_entry = '{level: in_level, parent: in_b};
      mem_req.rd_addr0 = in_a;
      mem_req.rd_addr1 = in_b;
      x_in       = x_ff;
      y_in       = y_ff;
      xe_in      = xe_ff;
      ye_in      = ye_ff;
      steps_in   = steps_ff;
      done       = 1'b0;
      done_found = 1'b0;
      case (state_ff)
         tlca_pkg::ST_IDLE: begin
            x_in     = in_a;
            y_in     = in_b;
            steps_in = '0;
         end
         tlca_pkg::ST_CHOOSE: begin
            // deeper node goes to x; second node wins a tie
            if (rd_data0.level > rd_data1.level) begin
               xe_in = rd_data0;
               ye_in = rd_data1;
            end else begin
               x_in  = y_ff;
               y_in  = x_ff;
               xe_in = rd_data1;
               ye_in = rd_data0;
            end
         end
         tlca_pkg::ST_LIFT_DEPTH: begin
            mem_req.rd_addr0 = xe_ff.parent;
            if (xe_ff.level != ye_ff.level) begin
               if (at_bound) begin
                  done = 1'b1;
               end else begin
                  x_in     = xe_ff.parent;
                  steps_in = steps_ff + 1'b1;
               end
            end
         end
         tlca_pkg::ST_WAIT_ONE: begin
            xe_in = rd_data0;
         end
         tlca_pkg::ST_LIFT_PAIR: begin
            mem_req.rd_addr0 = xe_ff.parent;
            mem_req.rd_addr1 = ye_ff.parent;
            if (x_ff == y_ff) begin
               done       = 1'b1;
               done_found = 1'b1;
            end else if (at_bound) begin
               done = 1'b1;
            end else begin
               x_in     = xe_ff.parent;
               y_in     = ye_ff.parent;
               steps_in = steps_ff + 1'b1;
            end
         end
         tlca_pkg::ST_WAIT_TWO: begin
            xe_in = rd_data0;
            ye_in = rd_data1;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   // result register: hold until taken, load when a query finishes
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_anc_in   = rsp_anc_ff;
      rsp_found_in = rsp_found_ff;
      if (done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = done_found;
         rsp_anc_in   = done_found ? x_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlca_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      xe_ff        <= xe_in;
      ye_ff        <= ye_in;
      steps_ff     <= steps_in;
      rsp_anc_ff   <= rsp_anc_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tlca_pkg::RSP_DATA_W - tlca_pkg::NODE_W){1'b0}}, rsp_anc_ff};
   assign rsp_tuser  = rsp_found_ff;

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && is_query) |=> (state_ff == tlca_pkg::ST_CHOOSE))
      else $error("query transaction did not start a climb");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlca_pkg::ST_LIFT_DEPTH || state_ff == tlca_pkg::ST_LIFT_PAIR)
      |-> (steps_ff <= STEP_MAX))
      else $error("step counter passed its bound");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_anc_ff == '0))
      else $error("failed climb reported a nonzero ancestor");

   a_wait_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlca_pkg::ST_WAIT_TWO) |=> (state_ff == tlca_pkg::ST_LIFT_PAIR))
      else $error("paired lift did not resume after table read");

endmodule

>>> design/tree_lca_by_parent_climb.sv
// ----------------------------------------------------------------------------
// tree_lca_by_parent_climb: lowest common ancestor by parent climbing
// Parent/depth table load and LCA query over a stream interface.
// ----------------------------------------------------------------------------
// A write transaction (req_tuser = 0) stores one node's parent and depth and
// returns nothing. A query transaction (req_tuser = 1) returns one result:
// the block reads both nodes, lifts the deeper one until depths match, then
// lifts both until they meet. Every lift waits on a registered read of the
// table, and the input is not ready while a query is in progress.
// A query needing more than NODE_COUNT steps ends with found (rsp_tuser) low
// and ancestor 0. Table entries must be written before they are read; the
// table is not cleared by reset. A finished result waits in an output register
// while the next transaction is taken.
module tree_lca_by_parent_climb #(
   parameter int NODE_COUNT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // node_a[9:0], node_b[19:10], node_level[29:20]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // ancestor[9:0]
   output logic        rsp_tuser    // found
);

   tlca_pkg::mem_req_type mem_req;
   tlca_pkg::entry_type   rd_data0;
   tlca_pkg::entry_type   rd_data1;

   tlca_table u_table (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   tlca_climb #(
      .NODE_COUNT (NODE_COUNT)
   ) u_climb (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mem_req    (mem_req),
      .rd_data0   (rd_data0),
      .rd_data1   (rd_data1)
   );

endmodule
